### src/assert_macros.svh
// Assertion macros shared by the bit timing solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication: when ante holds, cons holds in that cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/cbts_pkg.sv
// Package with widths, constants and shared types of the CAN bit timing solver.
package cbts_pkg;

   localparam int unsigned ClockW  = 32;
   localparam int unsigned RateW   = 24;
   localparam int unsigned TotalW  = 23;
   localparam int unsigned QuantaW = 5;
   localparam int unsigned StepW   = 6;
   localparam int unsigned RemW    = 24;

   localparam logic [ClockW-1:0]  CLOCK_RESET_HZ  = 32'd100000000;
   localparam logic [RateW-1:0]   MIN_RATE        = 24'd1000;
   localparam logic [RateW-1:0]   FAST_RATE       = 24'd1000000;
   localparam logic [QuantaW-1:0] FAST_MAX_QUANTA = 5'd10;
   localparam logic [QuantaW-1:0] SLOW_MAX_QUANTA = 5'd17;
   localparam logic [QuantaW-1:0] MIN_QUANTA      = 5'd3;
   localparam logic [TotalW-1:0]  MAX_PRESCALER   = 23'd256;
   localparam logic [QuantaW-1:0] MAX_SEG1        = 5'd16;
   localparam logic [QuantaW-1:0] MAX_SEG2        = 5'd8;
   localparam logic [14:0]        SP_LIMIT_PLUS1  = 15'd901;
   localparam logic [14:0]        SP_SCALE        = 15'd1000;

   localparam logic [StepW-1:0]   TOTAL_STEPS     = 6'd32;
   localparam logic [StepW-1:0]   QUANTA_STEPS    = 6'd23;

   typedef struct packed {
      logic              go;
      logic [ClockW-1:0] dividend;
      logic [RemW-1:0]   divisor;
      logic [StepW-1:0]  steps;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [ClockW-1:0] quotient;
      logic [RemW-1:0]   remainder;
   } div_sts_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] seg1_field;
      logic [2:0] seg2_field;
   } seg_split_type;

endpackage

### src/cbts_divider.sv
// Shared restoring divider that produces one quotient bit per cycle.
module cbts_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  cbts_pkg::div_cmd_type   cmd,
   output cbts_pkg::div_sts_type   sts
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [cbts_pkg::StepW-1:0]        count_ff, count_in;
   logic [cbts_pkg::RemW-1:0]         rem_ff, rem_in;
   logic [cbts_pkg::ClockW-1:0]       quo_ff, quo_in;
   logic [cbts_pkg::RemW-1:0]         divisor_ff, divisor_in;
   logic [cbts_pkg::RemW+1:0]         trial;

   always_comb begin
      trial      = {1'b0, rem_ff, quo_ff[cbts_pkg::ClockW-1]} - {2'b00, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (cmd.go) begin
         busy_in    = 1'b1;
         count_in   = cmd.steps;
         rem_in     = '0;
         quo_in     = cmd.dividend;
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         // With a nonzero divisor, the partial remainder always stays below it.
         if (!trial[cbts_pkg::RemW+1]) begin
            rem_in = trial[cbts_pkg::RemW-1:0];
         end else begin
            rem_in = {rem_ff[cbts_pkg::RemW-2:0], quo_ff[cbts_pkg::ClockW-1]};
         end
         quo_in   = {quo_ff[cbts_pkg::ClockW-2:0], ~trial[cbts_pkg::RemW+1]};
         count_in = count_ff - 1'b1;
         if (count_ff == {{(cbts_pkg::StepW-1){1'b0}}, 1'b1}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign sts.done      = done_ff;
   assign sts.quotient  = quo_ff;
   assign sts.remainder = rem_ff;

endmodule

### src/cbts_seg_split.sv
// Splits the quanta of one bit into the two time segments for the sample point.
module cbts_seg_split (
   input  logic [cbts_pkg::QuantaW-1:0] quanta,
   output cbts_pkg::seg_split_type      split
);

   logic [cbts_pkg::QuantaW-1:0] sum;
   logic [6:0]                   near_num, trunc_num;
   logic [cbts_pkg::QuantaW-1:0] s1_near, s1_trunc, s1, s2;
   logic                         degenerate, too_late;
   logic [14:0]                  sp_lhs, sp_rhs;

   always_comb begin
      sum        = quanta - 1'b1;
      near_num   = 7'(sum) * 7'd7 + 7'd3;
      s1_near    = {1'b0, near_num[6:3]};
      trunc_num  = 7'(sum) * 7'd7 - 7'd1;
      s1_trunc   = {1'b0, trunc_num[6:3]};
      degenerate = (sum <= s1_near);
      // The sample point exceeds 90 percent exactly when 1000 * (1 + s1) reaches
      // 901 times the bit length.
      sp_lhs     = cbts_pkg::SP_SCALE * 15'(s1_near + 1'b1);
      sp_rhs     = cbts_pkg::SP_LIMIT_PLUS1 * 15'(quanta);
      too_late   = (sp_lhs >= sp_rhs);
      s1         = too_late ? s1_trunc : s1_near;
      s2         = sum - s1;
      split.valid = !degenerate && (s1 != '0) && (s1 <= cbts_pkg::MAX_SEG1) &&
                    (s2 != '0) && (s2 <= cbts_pkg::MAX_SEG2);
      split.seg1_field = 4'(s1 - 1'b1);
      split.seg2_field = 3'(s2 - 1'b1);
   end

endmodule

### src/can_bit_timing_solver_core.sv
// Top level of the CAN bit timing solver: sequencer, registers and result stage.
// A bitrate below 1000 goes from acceptance straight to the result stage and strobe; otherwise
// k quanta counts (1 to 15) are tried in turn: the shared divider takes 32 steps for
// clock / bitrate, then 23 steps plus a decision per candidate.
// Throughput: one item at a time; busy falls in the strobe cycle, so the next item is taken
// at the edge ending it. Synchronous active-high reset idles and loads clock_hz = 100 MHz.
`include "assert_macros.svh"

module can_bit_timing_solver_core (
   input  logic                          clock,
   input  logic                          reset,
   // Command channel.
   input  logic                          start,
   output logic                          busy,
   input  logic [cbts_pkg::RateW-1:0]    req_bitrate,
   // Result strobe and fields; the receiver cannot stall.
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic [7:0]                    rsp_prescaler_field,
   output logic [3:0]                    rsp_seg1_field,
   output logic [2:0]                    rsp_seg2_field,
   output logic [1:0]                    rsp_jump_width_field,
   // Clock frequency register write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cbts_pkg::ClockW-1:0]   csr_clock_hz
);

   // One-hot sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_DIV_TOTAL = 4'b0010,
      ST_DIV_Q     = 4'b0100,
      ST_FINISH    = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [cbts_pkg::ClockW-1:0]        clock_hz_ff, clock_hz_in;
   logic                               fail_ff, fail_in;
   logic [cbts_pkg::TotalW-1:0]        total_ff, total_in;
   logic [cbts_pkg::RemW-1:0]          rem0_ff, rem0_in;
   logic [cbts_pkg::QuantaW-1:0]       quanta_ff, quanta_in;
   logic [cbts_pkg::TotalW-1:0]        presc_ff, presc_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_ok_ff, rsp_ok_in;
   logic [7:0]                         rsp_presc_ff, rsp_presc_in;
   logic [3:0]                         rsp_seg1_ff, rsp_seg1_in;
   logic [2:0]                         rsp_seg2_ff, rsp_seg2_in;
   logic [1:0]                         rsp_sjw_ff, rsp_sjw_in;

   cbts_pkg::div_cmd_type              div_cmd;
   cbts_pkg::div_sts_type              div_sts;
   cbts_pkg::seg_split_type            split;
   logic                               result_ok;
   logic                               fail_fields_zero;
   logic                               quanta_in_range;

   // The one shared arithmetic unit: both divisions run through it.
   cbts_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   // Segment split for the candidate quanta count that divided evenly.
   cbts_seg_split u_seg_split (
      .quanta (quanta_ff),
      .split  (split)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   always_comb begin
      clock_hz_in = clock_hz_ff;
      if (csr_valid && csr_ready) begin
         clock_hz_in = csr_clock_hz;
      end
   end

   // The bitrate is matched exactly when clock_hz / total equals the bitrate, and
   // with total = clock_hz / bitrate that holds exactly when the remainder of the
   // first division is below total. A zero prescaler is caught by the range check.
   assign result_ok = !fail_ff && (presc_ff != '0) && (presc_ff <= cbts_pkg::MAX_PRESCALER) &&
                      split.valid && ({1'b0, total_ff} > rem0_ff);

   always_comb begin
      state_in     = state_ff;
      fail_in      = fail_ff;
      total_in     = total_ff;
      rem0_in      = rem0_ff;
      quanta_in    = quanta_ff;
      presc_in     = presc_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_presc_in = rsp_presc_ff;
      rsp_seg1_in  = rsp_seg1_ff;
      rsp_seg2_in  = rsp_seg2_ff;
      rsp_sjw_in   = rsp_sjw_ff;
      div_cmd      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_bitrate < cbts_pkg::MIN_RATE) begin
                  fail_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  fail_in   = 1'b0;
                  quanta_in = (req_bitrate >= cbts_pkg::FAST_RATE) ?
                              cbts_pkg::FAST_MAX_QUANTA : cbts_pkg::SLOW_MAX_QUANTA;
                  div_cmd.go       = 1'b1;
                  div_cmd.dividend = clock_hz_ff;
                  div_cmd.divisor  = req_bitrate;
                  div_cmd.steps    = cbts_pkg::TOTAL_STEPS;
                  state_in         = ST_DIV_TOTAL;
               end
            end
         end
         ST_DIV_TOTAL: begin
            if (div_sts.done) begin
               // The bitrate is at least 1000, so the quotient fits in 23 bits.
               total_in = div_sts.quotient[cbts_pkg::TotalW-1:0];
               rem0_in  = div_sts.remainder;
               div_cmd.go       = 1'b1;
               div_cmd.dividend = {div_sts.quotient[cbts_pkg::TotalW-1:0],
                                   {(cbts_pkg::ClockW-cbts_pkg::TotalW){1'b0}}};
               div_cmd.divisor  = {{(cbts_pkg::RemW-cbts_pkg::QuantaW){1'b0}}, quanta_ff};
               div_cmd.steps    = cbts_pkg::QUANTA_STEPS;
               state_in         = ST_DIV_Q;
            end
         end
         ST_DIV_Q: begin
            if (div_sts.done) begin
               if (div_sts.remainder == '0) begin
                  presc_in = div_sts.quotient[cbts_pkg::TotalW-1:0];
                  state_in = ST_FINISH;
               end else if (quanta_ff <= cbts_pkg::MIN_QUANTA) begin
                  // No quanta count down to three divides the total evenly.
                  fail_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  quanta_in        = quanta_ff - 1'b1;
                  div_cmd.go       = 1'b1;
                  div_cmd.dividend = {total_ff, {(cbts_pkg::ClockW-cbts_pkg::TotalW){1'b0}}};
                  div_cmd.divisor  = {{(cbts_pkg::RemW-cbts_pkg::QuantaW){1'b0}},
                                      quanta_ff - 1'b1};
                  div_cmd.steps    = cbts_pkg::QUANTA_STEPS;
               end
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = result_ok;
            rsp_presc_in = result_ok ? 8'(presc_ff - 1'b1) : 8'd0;
            rsp_seg1_in  = result_ok ? split.seg1_field : 4'd0;
            rsp_seg2_in  = result_ok ? split.seg2_field : 3'd0;
            rsp_sjw_in   = result_ok ? 2'd1 : 2'd0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_hz_ff  <= cbts_pkg::CLOCK_RESET_HZ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_hz_ff  <= clock_hz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fail_ff      <= fail_in;
      total_ff     <= total_in;
      rem0_ff      <= rem0_in;
      quanta_ff    <= quanta_in;
      presc_ff     <= presc_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_presc_ff <= rsp_presc_in;
      rsp_seg1_ff  <= rsp_seg1_in;
      rsp_seg2_ff  <= rsp_seg2_in;
      rsp_sjw_ff   <= rsp_sjw_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ok               = rsp_ok_ff;
   assign rsp_prescaler_field  = rsp_presc_ff;
   assign rsp_seg1_field       = rsp_seg1_ff;
   assign rsp_seg2_field       = rsp_seg2_ff;
   assign rsp_jump_width_field = rsp_sjw_ff;

   assign fail_fields_zero = (rsp_prescaler_field == 8'd0) && (rsp_seg1_field == 4'd0) &&
                             (rsp_seg2_field == 3'd0) && (rsp_jump_width_field == 2'd0);
   assign quanta_in_range  = (quanta_ff >= cbts_pkg::MIN_QUANTA) &&
                             (quanta_ff <= cbts_pkg::SLOW_MAX_QUANTA);

   // A failed item carries all-zero fields.
   `ASSERT_IMPLIES(a_fail_fields_zero, clock, reset, rsp_valid && !rsp_ok, fail_fields_zero)
   // Each item yields one single-cycle strobe.
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   // The candidate quanta count stays within its search range.
   `ASSERT_IMPLIES(a_quanta_range, clock, reset, state_ff == ST_DIV_Q, quanta_in_range)
   // The divider only finishes while the sequencer waits for it.
   `ASSERT_IMPLIES(a_div_done_expected, clock, reset, div_sts.done, busy && !rsp_valid_in)
   // An accepted item makes the block busy.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

endmodule
